[src/longest_prefix_route_lookup_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the route lookup unit
// Concurrent checks are compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_UNIT_ASSERT_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_UNIT_ASSERT_SVH

`ifndef SYNTH
// Check a property at every clock edge outside reset
`define LPR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lpr: assertion failed");
// Check that a condition leads to a consequence in the next cycle
`define LPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpr: assertion failed");
`else
`define LPR_ASSERT_ALWAYS(lbl, prop)
`define LPR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/lpr_pkg.sv]
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants of the longest-prefix route lookup unit.
// ----------------------------------------------------------------------------
package lpr_pkg;

  // Default table depth
  localparam int LPR_ROUTES = 16;

  // Item kinds
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // Next hop value meaning "directly connected"
  localparam logic [31:0] LPR_DIRECT_GW = 32'h0000_0000;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_FULL    = 2'd2
  } lpr_status_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] address;
    logic [31:0] prefix_mask;
    logic [31:0] gateway;
    logic [2:0]  port_index;
  } lpr_in_t;

  typedef struct packed {
    lpr_status_t status;
    logic [2:0]  out_port;
    logic [31:0] next_hop;
  } lpr_out_t;

  // One stored route
  typedef struct packed {
    logic [31:0] network;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [2:0]  port;
  } lpr_entry_t;

endpackage

[src/lpr_table.sv]
// ----------------------------------------------------------------------------
// lpr_table
// Route storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lpr_table #(
  parameter int ROUTES = lpr_pkg::LPR_ROUTES,
  localparam int AW    = (ROUTES > 1) ? $clog2(ROUTES) : 1
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  lpr_pkg::lpr_entry_t wr_entry,
  input  logic [AW-1:0]      rd_addr,
  output lpr_pkg::lpr_entry_t rd_entry_r
);

  lpr_pkg::lpr_entry_t mem_r [ROUTES];

  // Write a new route
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_entry;
    end
  end

  // Read one route per cycle
  always_ff @(posedge clk) begin
    rd_entry_r <= mem_r[rd_addr];
  end

endmodule

[src/lpr_match.sv]
// ----------------------------------------------------------------------------
// lpr_match
// Shared compare unit: prefix match of one entry and longest-mask selection.
// ----------------------------------------------------------------------------
module lpr_match (
  input  logic [31:0]         dst,
  input  lpr_pkg::lpr_entry_t entry,
  input  logic                have_best,
  input  logic [31:0]         best_mask,
  output logic                take
);

  logic hit;

  // Match on masked destination; equal mask lets the newer entry win
  assign hit  = ((dst & entry.mask) == entry.network);
  assign take = hit && (!have_best || (entry.mask >= best_mask));

endmodule

[src/lpr_ctrl.sv]
// ----------------------------------------------------------------------------
// lpr_ctrl
// Sequencer: appends routes, scans the table one entry per cycle for a
// lookup and holds the result beat in an output register.
// ----------------------------------------------------------------------------
`include "longest_prefix_route_lookup_unit_assert.svh"

module lpr_ctrl #(
  parameter int ROUTES = lpr_pkg::LPR_ROUTES,
  localparam int AW    = (ROUTES > 1) ? $clog2(ROUTES) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpr_pkg::lpr_in_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lpr_pkg::lpr_out_t   out_data,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output lpr_pkg::lpr_entry_t wr_entry,
  output logic [AW-1:0]       rd_addr,
  input  lpr_pkg::lpr_entry_t rd_entry
);

  localparam int CW = $clog2(ROUTES + 1);
  localparam logic [CW-1:0] FILL_MAX = CW'(ROUTES);
  localparam logic [CW-1:0] FILL_ONE = CW'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              chk_r, chk_nxt;
  logic              found_r, found_nxt;
  logic [31:0]       best_mask_r, best_mask_nxt;
  logic [31:0]       best_gw_r, best_gw_nxt;
  logic [2:0]        best_port_r, best_port_nxt;
  logic [31:0]       dst_r, dst_nxt;
  lpr_pkg::lpr_out_t res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  lpr_pkg::lpr_out_t out_data_r, out_data_nxt;

  logic in_fire;
  logic full;
  logic issue;
  logic take;

  // Compare the entry read last cycle against the destination
  lpr_match u_match (
    .dst       (dst_r),
    .entry     (rd_entry),
    .have_best (found_r),
    .best_mask (best_mask_r),
    .take      (take)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign full     = (fill_r == FILL_MAX);
  assign issue    = (state_r == S_SCAN) && (idx_r < fill_r);

  // Append at the fill position
  assign wr_en             = in_fire && (in_data.mode == lpr_pkg::MODE_ADD) && !full;
  assign wr_addr           = fill_r[AW-1:0];
  assign wr_entry.network  = in_data.address;
  assign wr_entry.mask     = in_data.prefix_mask;
  assign wr_entry.gateway  = in_data.gateway;
  assign wr_entry.port     = in_data.port_index;
  assign rd_addr           = idx_r[AW-1:0];

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    chk_nxt       = 1'b0;
    found_nxt     = found_r;
    best_mask_nxt = best_mask_r;
    best_gw_nxt   = best_gw_r;
    best_port_nxt = best_port_r;
    dst_nxt       = dst_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // Drop the result beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.mode == lpr_pkg::MODE_ADD) begin
            res_nxt.out_port = 3'd0;
            res_nxt.next_hop = 32'd0;
            if (full) begin
              res_nxt.status = lpr_pkg::ST_FULL;
            end else begin
              res_nxt.status = lpr_pkg::ST_OK;
              fill_nxt       = fill_r + FILL_ONE;
            end
            state_nxt = S_RESULT;
          end else begin
            dst_nxt   = in_data.address;
            idx_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Issue the next read while comparing the previous one
        chk_nxt = issue;
        if (issue) begin
          idx_nxt = idx_r + FILL_ONE;
        end
        if (chk_r && take) begin
          found_nxt     = 1'b1;
          best_mask_nxt = rd_entry.mask;
          best_gw_nxt   = rd_entry.gateway;
          best_port_nxt = rd_entry.port;
        end
        if (!issue && !chk_r) begin
          if (found_r) begin
            res_nxt.status   = lpr_pkg::ST_OK;
            res_nxt.out_port = best_port_r;
            res_nxt.next_hop = (best_gw_r != lpr_pkg::LPR_DIRECT_GW) ? best_gw_r : dst_r;
          end else begin
            res_nxt.status   = lpr_pkg::ST_NOMATCH;
            res_nxt.out_port = 3'd0;
            res_nxt.next_hop = 32'd0;
          end
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    best_mask_r <= best_mask_nxt;
    best_gw_r   <= best_gw_nxt;
    best_port_r <= best_port_nxt;
    dst_r       <= dst_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      chk_r       <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      chk_r       <= chk_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `LPR_ASSERT_ALWAYS(a_fill_bound, fill_r <= FILL_MAX)
  `LPR_ASSERT_NEXT(a_add_grows, wr_en, fill_r == ($past(fill_r) + FILL_ONE))
  `LPR_ASSERT_ALWAYS(a_scan_idx, (state_r != S_SCAN) || (idx_r <= fill_r))
  `LPR_ASSERT_ALWAYS(a_chk_in_scan, !chk_r || (state_r == S_SCAN))
  `LPR_ASSERT_NEXT(a_result_load, (state_r == S_RESULT) && (!out_valid_r || out_ready), out_valid_r && (out_data_r == $past(res_r)))

endmodule

[src/longest_prefix_route_lookup_unit.sv]
// An add beat appends a route (network, mask, next hop, port) at the fill
// position and answers ok, or table full once ROUTES routes are stored. A
// lookup beat reads the stored routes one per cycle through the single table
// read port and one shared compare unit. The longest mask wins and the newer
// route wins a tie; a zero next hop returns the destination. The table is
// empty after reset. The block takes one beat at a time; the next beat is
// accepted while the previous result waits on out_, and a result stays in the
// sequencer while that earlier one is still unread.
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_unit
// Top level: route table storage and lookup sequencer.
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup_unit #(
  parameter int ROUTES = lpr_pkg::LPR_ROUTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpr_pkg::lpr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lpr_pkg::lpr_out_t out_data
);

  localparam int AW = (ROUTES > 1) ? $clog2(ROUTES) : 1;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  lpr_pkg::lpr_entry_t wr_entry;
  logic [AW-1:0]       rd_addr;
  lpr_pkg::lpr_entry_t rd_entry;

  // Route storage
  lpr_table #(
    .ROUTES (ROUTES)
  ) u_table (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_entry   (wr_entry),
    .rd_addr    (rd_addr),
    .rd_entry_r (rd_entry)
  );

  // Sequencer and compare
  lpr_ctrl #(
    .ROUTES (ROUTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_entry  (wr_entry),
    .rd_addr   (rd_addr),
    .rd_entry  (rd_entry)
  );

endmodule
